// ===== sv/mtep_pkg.sv =====
// Types and constants for the MIDI track event parser.
// Shared by midi_track_event_parser_top and its testbench tb_top; depends on nothing else.
package mtep_pkg;

    // One byte of the track chunk body.
    typedef struct packed {
        logic [7:0] track_byte;
        logic       end_of_track;
    } in_item_t;

    // One decoded result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [27:0] delta_ticks;
        logic [3:0]  event_type;
        logic [3:0]  channel_number;
        logic [7:0]  first_param;
        logic [7:0]  second_param;
        logic [7:0]  meta_kind;
        logic [27:0] payload_length;
        logic [7:0]  payload_byte;
        logic        event_done;
        logic [1:0]  error_code;
    } out_item_t;

    typedef enum logic [3:0] {
        PH_DELTA     = 4'd0,
        PH_STATUS    = 4'd1,
        PH_META_TYPE = 4'd2,
        PH_LENGTH    = 4'd3,
        PH_PAYLOAD   = 4'd4,
        PH_PARAM1    = 4'd5,
        PH_PARAM2    = 4'd6
    } phase_t;

    localparam logic [2:0] KIND_CHANNEL      = 3'd0;
    localparam logic [2:0] KIND_META_HEADER  = 3'd1;
    localparam logic [2:0] KIND_META_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_SYSEX_HEADER = 3'd3;
    localparam logic [2:0] KIND_ERROR        = 3'd4;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NO_RUNNING = 2'd1;
    localparam logic [1:0] ERR_OVERLONG   = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

    localparam logic [7:0] STATUS_META   = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
    localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
    localparam logic [7:0] DATA_MASK     = 8'h7F;
    localparam logic [7:0] STATUS_BIT    = 8'h80;
    localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

    localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
    localparam logic [3:0] TYPE_PRESSURE = 4'hD;

endpackage

// ===== sv/midi_track_event_parser_top.sv =====
// Top level of the MIDI track event parser: byte-wide track decoder and result register.
// Depends on mtep_pkg for the item types, phase codes and constants.
//
// Usage:
//   s_valid/s_ready/s_data carry one byte of a track chunk body per item, with
//   end_of_track set on the final byte of the chunk. m_valid/m_ready/m_data carry
//   decoded results: channel events, meta headers, meta payload bytes, sysex
//   headers and errors. A byte gives zero or one result.
//   Throughput: one byte per cycle while s_ready is high. Each byte only moves
//   a small phase machine and a 28-bit variable-length quantity accumulator.
//   Latency: a result appears on m_data the cycle after the byte that causes it
//   is accepted.
//   Stalls: the result register holds a waiting result; a new byte is still
//   taken in the same cycle that the receiver takes the waiting result, so a
//   stream with m_ready held high never pauses. While a result waits and
//   m_ready is low, s_ready drops.
//   Reset (aresetn low, synchronous): empty the result register, clear the
//   running status and expect a delta time. The final byte of a chunk does the
//   same to the parser state.
//   Errors are reported as results of kind error; parsing then expects a delta.
module midi_track_event_parser_top #(
    parameter int MAX_QUANTITY_BYTES = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mtep_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mtep_pkg::out_item_t m_data
);

    // Counter wide enough to hold the byte limit itself.
    localparam int QB_W = $clog2(MAX_QUANTITY_BYTES + 1);

    mtep_pkg::phase_t    phase_reg, phase_next;
    logic [27:0]         acc_reg, acc_next;
    logic [QB_W-1:0]     qb_reg, qb_next;
    logic [27:0]         held_delta_reg, held_delta_next;
    logic [27:0]         remaining_reg, remaining_next;
    logic [3:0]          run_type_reg, run_type_next;
    logic [3:0]          run_chan_reg, run_chan_next;
    logic                run_valid_reg, run_valid_next;
    logic [7:0]          held_param_reg, held_param_next;
    logic [7:0]          held_meta_reg, held_meta_next;
    logic                in_sysex_reg, in_sysex_next;

    logic                m_valid_reg, m_valid_next;
    mtep_pkg::out_item_t m_data_reg, m_data_next;

    logic                accept;
    logic [7:0]          b;
    logic                eot;

    // Quantity byte decode, shared by delta time and length phases.
    logic [27:0]         q_val;
    logic [QB_W-1:0]     q_cnt;
    logic                q_cont;
    logic                q_over;
    logic [27:0]         rem_dec;
    logic                one_byte;

    mtep_pkg::out_item_t res;
    logic                have;
    logic [1:0]          err;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign b        = s_data.track_byte;
    assign eot      = s_data.end_of_track;
    assign q_val    = {acc_reg[20:0], b[6:0] & mtep_pkg::DATA_MASK[6:0]};
    assign q_cnt    = qb_reg + QB_W'(1);
    assign q_cont   = (b & mtep_pkg::STATUS_BIT) != 8'd0;
    assign q_over   = q_cont && (q_cnt >= QB_W'(MAX_QUANTITY_BYTES));
    assign rem_dec  = (remaining_reg != 28'd0) ? remaining_reg - 28'd1 : 28'd0;
    assign one_byte = (run_type_reg == mtep_pkg::TYPE_PROGRAM) ||
                      (run_type_reg == mtep_pkg::TYPE_PRESSURE);

    always_comb begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        qb_next         = qb_reg;
        held_delta_next = held_delta_reg;
        remaining_next  = remaining_reg;
        run_type_next   = run_type_reg;
        run_chan_next   = run_chan_reg;
        run_valid_next  = run_valid_reg;
        held_param_next = held_param_reg;
        held_meta_next  = held_meta_reg;
        in_sysex_next   = in_sysex_reg;
        res             = '0;
        have            = 1'b0;
        err             = mtep_pkg::ERR_NONE;

        case (phase_reg)
            mtep_pkg::PH_STATUS: begin
                if (b == mtep_pkg::STATUS_META) begin
                    phase_next = mtep_pkg::PH_META_TYPE;
                end else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESCAPE) begin
                    in_sysex_next = 1'b1;
                    phase_next    = mtep_pkg::PH_LENGTH;
                end else if (q_cont) begin
                    run_type_next  = b[7:4];
                    run_chan_next  = 4'(b & mtep_pkg::NIBBLE_MASK);
                    run_valid_next = 1'b1;
                    phase_next     = mtep_pkg::PH_PARAM1;
                end else if (!run_valid_reg) begin
                    err = mtep_pkg::ERR_NO_RUNNING;
                end else begin
                    // Running status: this byte is the first data byte.
                    held_param_next = b;
                    if (one_byte) begin
                        res.kind           = mtep_pkg::KIND_CHANNEL;
                        res.delta_ticks    = held_delta_reg;
                        res.event_type     = run_type_reg;
                        res.channel_number = run_chan_reg;
                        res.first_param    = b;
                        res.event_done     = 1'b1;
                        have               = 1'b1;
                        phase_next         = mtep_pkg::PH_DELTA;
                    end else begin
                        phase_next = mtep_pkg::PH_PARAM2;
                    end
                end
            end
            mtep_pkg::PH_META_TYPE: begin
                held_meta_next = b;
                in_sysex_next  = 1'b0;
                phase_next     = mtep_pkg::PH_LENGTH;
            end
            mtep_pkg::PH_LENGTH: begin
                if (q_cont) begin
                    if (q_over) begin
                        err = mtep_pkg::ERR_OVERLONG;
                    end else begin
                        acc_next = q_val;
                        qb_next  = q_cnt;
                    end
                end else begin
                    acc_next           = '0;
                    qb_next            = '0;
                    remaining_next     = q_val;
                    res.kind           = in_sysex_reg ? mtep_pkg::KIND_SYSEX_HEADER
                                                      : mtep_pkg::KIND_META_HEADER;
                    res.delta_ticks    = held_delta_reg;
                    res.meta_kind      = in_sysex_reg ? 8'd0 : held_meta_reg;
                    res.payload_length = q_val;
                    res.event_done     = in_sysex_reg || (q_val == 28'd0);
                    have               = 1'b1;
                    phase_next         = (q_val == 28'd0) ? mtep_pkg::PH_DELTA
                                                          : mtep_pkg::PH_PAYLOAD;
                end
            end
            mtep_pkg::PH_PAYLOAD: begin
                remaining_next = rem_dec;
                if (!in_sysex_reg) begin
                    res.kind         = mtep_pkg::KIND_META_PAYLOAD;
                    res.delta_ticks  = held_delta_reg;
                    res.meta_kind    = held_meta_reg;
                    res.payload_byte = b;
                    res.event_done   = (rem_dec == 28'd0);
                    have             = 1'b1;
                end
                if (rem_dec == 28'd0) begin
                    phase_next = mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_PARAM1: begin
                held_param_next = b;
                if (one_byte) begin
                    res.kind           = mtep_pkg::KIND_CHANNEL;
                    res.delta_ticks    = held_delta_reg;
                    res.event_type     = run_type_reg;
                    res.channel_number = run_chan_reg;
                    res.first_param    = b;
                    res.event_done     = 1'b1;
                    have               = 1'b1;
                    phase_next         = mtep_pkg::PH_DELTA;
                end else begin
                    phase_next = mtep_pkg::PH_PARAM2;
                end
            end
            mtep_pkg::PH_PARAM2: begin
                res.kind           = mtep_pkg::KIND_CHANNEL;
                res.delta_ticks    = held_delta_reg;
                res.event_type     = run_type_reg;
                res.channel_number = run_chan_reg;
                res.first_param    = held_param_reg;
                res.second_param   = b;
                res.event_done     = 1'b1;
                have               = 1'b1;
                phase_next         = mtep_pkg::PH_DELTA;
            end
            default: begin
                // Delta time; unused phase codes fall here as well.
                if (q_cont) begin
                    if (q_over) begin
                        err = mtep_pkg::ERR_OVERLONG;
                    end else begin
                        acc_next = q_val;
                        qb_next  = q_cnt;
                    end
                end else begin
                    acc_next        = '0;
                    qb_next         = '0;
                    held_delta_next = q_val;
                    phase_next      = mtep_pkg::PH_STATUS;
                end
            end
        endcase

        // Abandon the event on an error; flag a chunk that ends mid-event.
        if (err != mtep_pkg::ERR_NONE) begin
            phase_next = mtep_pkg::PH_DELTA;
            acc_next   = '0;
            qb_next    = '0;
        end else if (eot && !(phase_next == mtep_pkg::PH_DELTA && qb_next == '0)) begin
            err = mtep_pkg::ERR_TRUNCATED;
        end
        if (err != mtep_pkg::ERR_NONE) begin
            res            = '0;
            res.kind       = mtep_pkg::KIND_ERROR;
            res.event_done = 1'b1;
            res.error_code = err;
            have           = 1'b1;
        end

        // Final byte of the chunk: return all parser state to reset.
        if (eot) begin
            phase_next      = mtep_pkg::PH_DELTA;
            acc_next        = '0;
            qb_next         = '0;
            held_delta_next = '0;
            remaining_next  = '0;
            run_type_next   = '0;
            run_chan_next   = '0;
            run_valid_next  = 1'b0;
            held_param_next = '0;
            held_meta_next  = '0;
            in_sysex_next   = 1'b0;
        end

        // Result register: load on accept, drain when the receiver takes it.
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next = have;
            if (have) begin
                m_data_next = res;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= mtep_pkg::PH_DELTA;
            acc_reg        <= '0;
            qb_reg         <= '0;
            held_delta_reg <= '0;
            remaining_reg  <= '0;
            run_type_reg   <= '0;
            run_chan_reg   <= '0;
            run_valid_reg  <= 1'b0;
            held_param_reg <= '0;
            held_meta_reg  <= '0;
            in_sysex_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                acc_reg        <= acc_next;
                qb_reg         <= qb_next;
                held_delta_reg <= held_delta_next;
                remaining_reg  <= remaining_next;
                run_type_reg   <= run_type_next;
                run_chan_reg   <= run_chan_next;
                run_valid_reg  <= run_valid_next;
                held_param_reg <= held_param_next;
                held_meta_reg  <= held_meta_next;
                in_sysex_reg   <= in_sysex_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // Error results always close their event and carry a code.
    a_error_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == mtep_pkg::KIND_ERROR
        |-> m_data.event_done && m_data.error_code != mtep_pkg::ERR_NONE)
        else $error("error result without code or event_done");

    // Other results never carry an error code.
    a_no_stray_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != mtep_pkg::KIND_ERROR
        |-> m_data.error_code == mtep_pkg::ERR_NONE)
        else $error("error code on a non-error result");

    // The final byte of a chunk returns the parser to its reset state.
    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.end_of_track
        |=> phase_reg == mtep_pkg::PH_DELTA && qb_reg == '0 && !run_valid_reg)
        else $error("parser state not cleared after end of track");

    // The quantity byte count stays below the limit between bytes.
    a_qb_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qb_reg < QB_W'(MAX_QUANTITY_BYTES))
        else $error("quantity byte count reached the limit");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for midi_track_event_parser_top: directed and random track chunks.
// Depends on mtep_pkg and the parser RTL; predicts every result with its own parser model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Quantity length limit, handed to the block so both sides agree.
    localparam int MAX_VLQ_BYTES = 4;

    // Outcomes of feeding one byte of a variable-length quantity.
    localparam int VLQ_MORE     = 0;
    localparam int VLQ_DONE     = 1;
    localparam int VLQ_OVERLONG = 2;

    // Size of the random part, in track bytes.
    localparam int RANDOM_BYTES = 900;

    // One byte waiting to be offered, with a flag that makes the sender hold
    // it back until every outstanding result has arrived.
    typedef struct packed {
        mtep_pkg::in_item_t item;
        logic               drain_first;
    } pending_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    mtep_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    mtep_pkg::out_item_t m_data;

    pending_t            pending_items[$];
    mtep_pkg::out_item_t expected_results[$];
    logic [7:0]          chunk_bytes[$];

    // Flow control and bookkeeping.
    bit          item_taken;
    bit          hold_next;
    bit          mid_hold_done;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          total_items;
    int          accepted_count;
    int          result_count;
    int          mismatch_total;
    int          chunk_count;
    int          kind_seen[5];
    int          error_seen[4];

    // Own copy of the parser state.
    mtep_pkg::phase_t cur_phase;
    logic [27:0] vlq_accum;
    int          vlq_count;
    logic [27:0] cur_delta;
    logic [27:0] skip_left;
    logic [3:0]  run_type;
    logic [3:0]  run_chan;
    bit          run_ok;
    logic [7:0]  held_data;
    logic [7:0]  meta_code;
    bit          sysex_open;

    // Generator's own idea of running status within the chunk being built.
    bit          gen_run_ok;
    logic [3:0]  gen_run_type;

    midi_track_event_parser_top #(
        .MAX_QUANTITY_BYTES(MAX_VLQ_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    task automatic clear_parser_state();
        cur_phase  = mtep_pkg::PH_DELTA;
        vlq_accum  = '0;
        vlq_count  = 0;
        cur_delta  = '0;
        skip_left  = '0;
        run_type   = '0;
        run_chan   = '0;
        run_ok     = 1'b0;
        held_data  = '0;
        meta_code  = '0;
        sysex_open = 1'b0;
    endtask

    // Shift one byte into the quantity accumulator; the top bit says more follow.
    function automatic int take_vlq_byte(input logic [7:0] b, output logic [27:0] value);
        value = '0;
        vlq_accum = (vlq_accum << 7) | 28'(b & mtep_pkg::DATA_MASK);
        vlq_count = vlq_count + 1;
        if (b[7]) begin
            if (vlq_count >= MAX_VLQ_BYTES) begin
                vlq_accum = '0;
                vlq_count = 0;
                return VLQ_OVERLONG;
            end
            return VLQ_MORE;
        end
        value = vlq_accum;
        vlq_accum = '0;
        vlq_count = 0;
        return VLQ_DONE;
    endfunction

    function automatic mtep_pkg::out_item_t channel_item(input logic [7:0] p1,
                                                         input logic [7:0] p2);
        mtep_pkg::out_item_t r;
        r = '0;
        r.kind           = mtep_pkg::KIND_CHANNEL;
        r.delta_ticks    = cur_delta;
        r.event_type     = run_type;
        r.channel_number = run_chan;
        r.first_param    = p1;
        r.second_param   = p2;
        r.event_done     = 1'b1;
        return r;
    endfunction

    // Advance the model by one accepted byte and queue the result it causes.
    task automatic decode_track_byte(input mtep_pkg::in_item_t it);
        mtep_pkg::out_item_t r;
        logic [7:0]  b;
        logic [27:0] val;
        logic [1:0]  err;
        bit          have;
        int          q;
        r    = '0;
        b    = it.track_byte;
        val  = '0;
        err  = mtep_pkg::ERR_NONE;
        have = 1'b0;
        case (cur_phase)
            mtep_pkg::PH_STATUS: begin
                if (b == mtep_pkg::STATUS_META) begin
                    cur_phase = mtep_pkg::PH_META_TYPE;
                end else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESCAPE) begin
                    sysex_open = 1'b1;
                    cur_phase  = mtep_pkg::PH_LENGTH;
                end else if ((b & mtep_pkg::STATUS_BIT) != 0) begin
                    run_type  = b[7:4];
                    run_chan  = 4'(b & mtep_pkg::NIBBLE_MASK);
                    run_ok    = 1'b1;
                    cur_phase = mtep_pkg::PH_PARAM1;
                end else if (!run_ok) begin
                    err = mtep_pkg::ERR_NO_RUNNING;
                end else begin
                    held_data = b;
                    if (run_type == mtep_pkg::TYPE_PROGRAM ||
                        run_type == mtep_pkg::TYPE_PRESSURE) begin
                        r         = channel_item(b, 8'h00);
                        have      = 1'b1;
                        cur_phase = mtep_pkg::PH_DELTA;
                    end else begin
                        cur_phase = mtep_pkg::PH_PARAM2;
                    end
                end
            end
            mtep_pkg::PH_META_TYPE: begin
                meta_code  = b;
                sysex_open = 1'b0;
                cur_phase  = mtep_pkg::PH_LENGTH;
            end
            mtep_pkg::PH_LENGTH: begin
                q = take_vlq_byte(b, val);
                if (q == VLQ_OVERLONG) begin
                    err = mtep_pkg::ERR_OVERLONG;
                end else if (q == VLQ_DONE) begin
                    skip_left        = val;
                    r.kind           = sysex_open ? mtep_pkg::KIND_SYSEX_HEADER
                                                  : mtep_pkg::KIND_META_HEADER;
                    r.delta_ticks    = cur_delta;
                    r.meta_kind      = sysex_open ? 8'h00 : meta_code;
                    r.payload_length = val;
                    r.event_done     = sysex_open || (val == 0);
                    have             = 1'b1;
                    cur_phase        = (val == 0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_PAYLOAD;
                end
            end
            mtep_pkg::PH_PAYLOAD: begin
                if (skip_left != 0) skip_left = skip_left - 28'd1;
                if (!sysex_open) begin
                    r.kind         = mtep_pkg::KIND_META_PAYLOAD;
                    r.delta_ticks  = cur_delta;
                    r.meta_kind    = meta_code;
                    r.payload_byte = b;
                    r.event_done   = (skip_left == 0);
                    have           = 1'b1;
                end
                if (skip_left == 0) cur_phase = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_PARAM1: begin
                held_data = b;
                if (run_type == mtep_pkg::TYPE_PROGRAM || run_type == mtep_pkg::TYPE_PRESSURE) begin
                    r         = channel_item(b, 8'h00);
                    have      = 1'b1;
                    cur_phase = mtep_pkg::PH_DELTA;
                end else begin
                    cur_phase = mtep_pkg::PH_PARAM2;
                end
            end
            mtep_pkg::PH_PARAM2: begin
                r         = channel_item(held_data, b);
                have      = 1'b1;
                cur_phase = mtep_pkg::PH_DELTA;
            end
            default: begin
                q = take_vlq_byte(b, val);
                if (q == VLQ_OVERLONG) begin
                    err = mtep_pkg::ERR_OVERLONG;
                end else if (q == VLQ_DONE) begin
                    cur_delta = val;
                    cur_phase = mtep_pkg::PH_STATUS;
                end
            end
        endcase

        // An error abandons the event; a final byte mid-event is a truncation.
        if (err != mtep_pkg::ERR_NONE) begin
            cur_phase = mtep_pkg::PH_DELTA;
            vlq_accum = '0;
            vlq_count = 0;
        end else if (it.end_of_track &&
                     !(cur_phase == mtep_pkg::PH_DELTA && vlq_count == 0)) begin
            err = mtep_pkg::ERR_TRUNCATED;
        end
        if (err != mtep_pkg::ERR_NONE) begin
            r            = '0;
            r.kind       = mtep_pkg::KIND_ERROR;
            r.event_done = 1'b1;
            r.error_code = err;
            have         = 1'b1;
        end
        if (it.end_of_track) clear_parser_state();
        if (have) expected_results = {expected_results, r};
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b, input logic eot);
        pending_t p;
        p.item.track_byte   = b;
        p.item.end_of_track = eot;
        p.drain_first       = hold_next;
        hold_next           = 1'b0;
        pending_items       = {pending_items, p};
    endtask

    // Append one byte to the chunk being built.
    task automatic add_byte(input logic [7:0] v);
        chunk_bytes = {chunk_bytes, v};
    endtask

    // Encode a quantity, optionally padded with leading continuation bytes.
    task automatic add_vlq(input logic [27:0] value, input int min_len);
        int n;
        int i;
        logic [7:0] g;
        n = 1;
        while (n < 4 && (value >> (7 * n)) != 0) n++;
        if (min_len > n) n = min_len;
        for (i = n - 1; i >= 0; i--) begin
            g = 8'((value >> (7 * i)) & 28'h7F);
            if (i > 0) g = g | mtep_pkg::STATUS_BIT;
            add_byte(g);
        end
    endtask

    function automatic logic [27:0] rand_quantity();
        case ($urandom_range(0, 9))
            6, 7:    return 28'($urandom_range(0, 16383));
            8:       return 28'($urandom_range(0, 2097151));
            9:       return 28'($urandom_range(0, 28'hFFFFFFF));
            default: return 28'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic int rand_pad();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(2, 4) : 1;
    endfunction

    // Mostly proper data bytes; now and then one with the top bit set.
    function automatic logic [7:0] rand_data();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                           : 8'($urandom_range(0, 127));
    endfunction

    task automatic add_overlong();
        repeat (MAX_VLQ_BYTES) add_byte(mtep_pkg::STATUS_BIT | 8'($urandom_range(0, 127)));
    endtask

    task automatic add_channel_event();
        logic [7:0] s;
        int k;
        add_vlq(rand_quantity(), rand_pad());
        if (gen_run_ok && $urandom_range(0, 99) < 40) begin
            // Running status: the first data byte must not look like a status.
            add_byte(8'($urandom_range(0, 127)));
        end else begin
            if ($urandom_range(0, 7) == 0) begin
                // System statuses other than meta and sysex behave as type 15.
                k = $urandom_range(1, 13);
                s = (k <= 6) ? 8'(8'hF0 + k) : 8'(8'hF1 + k);
            end else begin
                s = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
            end
            add_byte(s);
            gen_run_ok   = 1'b1;
            gen_run_type = s[7:4];
            add_byte(rand_data());
        end
        if (gen_run_type != mtep_pkg::TYPE_PROGRAM && gen_run_type != mtep_pkg::TYPE_PRESSURE)
            add_byte(rand_data());
    endtask

    task automatic add_meta_or_sysex(input bit is_meta);
        int n;
        add_vlq(rand_quantity(), rand_pad());
        if (is_meta) begin
            add_byte(mtep_pkg::STATUS_META);
            add_byte(8'($urandom_range(0, 255)));
        end else begin
            add_byte($urandom_range(0, 1) ? mtep_pkg::STATUS_SYSEX : mtep_pkg::STATUS_ESCAPE);
        end
        n = $urandom_range(0, 5);
        add_vlq(28'(n), rand_pad());
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endtask

    // Broken events: data without a status, or a quantity that runs too long.
    task automatic add_broken_event();
        if (!gen_run_ok && $urandom_range(0, 1)) begin
            add_vlq(rand_quantity(), 1);
            add_byte(8'($urandom_range(0, 127)));
        end else begin
            case ($urandom_range(0, 2))
                0: add_overlong();
                1: begin
                    add_vlq(rand_quantity(), 1);
                    add_byte(mtep_pkg::STATUS_META);
                    add_byte(8'($urandom_range(0, 255)));
                    add_overlong();
                end
                default: begin
                    add_vlq(rand_quantity(), 1);
                    add_byte(mtep_pkg::STATUS_SYSEX);
                    add_overlong();
                end
            endcase
        end
    endtask

    task automatic add_any_event();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)      add_channel_event();
        else if (pick < 75) add_meta_or_sysex(1'b1);
        else if (pick < 85) add_meta_or_sysex(1'b0);
        else if (pick < 95) add_broken_event();
        else repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
    endtask

    // Build one chunk and queue it, end_of_track on its last byte.
    task automatic queue_random_chunk();
        int mode;
        int start_size;
        int cut;
        int i;
        chunk_bytes.delete();
        gen_run_ok = 1'b0;
        repeat ($urandom_range(1, 10)) add_any_event();
        mode = $urandom_range(0, 99);
        if (mode < 70) begin
            // Proper end-of-track meta event.
            add_vlq(rand_quantity(), 1);
            add_byte(mtep_pkg::STATUS_META);
            add_byte(8'h2F);
            add_byte(8'h00);
        end else if (mode < 85) begin
            // Chop the final event at a random point.
            start_size = chunk_bytes.size();
            add_any_event();
            cut = $urandom_range(0, chunk_bytes.size() - start_size);
            repeat (cut) if (chunk_bytes.size() > 1) void'(chunk_bytes.pop_back());
        end else if (mode < 93) begin
            // A long payload cut short, to reach the wide length bits.
            add_vlq(rand_quantity(), 1);
            if ($urandom_range(0, 1)) begin
                add_byte(mtep_pkg::STATUS_META);
                add_byte(8'($urandom_range(0, 255)));
            end else begin
                add_byte(mtep_pkg::STATUS_SYSEX);
            end
            add_vlq(28'($urandom_range(6, 28'hFFFFFFF)), 1);
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
        end
        for (i = 0; i < chunk_bytes.size(); i++)
            queue_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
        chunk_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: offer a new item at the falling edge, hold it until taken
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
                (!pending_items[0].drain_first || expected_results.size() == 0)) begin
                s_data  <= pending_items[0].item;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, at the rate the current stage sets.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Note each accepted item, predict its result and step through the idle stages.
    always @(posedge aclk) begin
        item_taken = aresetn && s_valid && s_ready;
        if (item_taken) begin
            decode_track_byte(s_data);
            void'(pending_items.pop_front());
            accepted_count++;
            if (accepted_count == total_items / 3) begin
                send_idle_pct = 62;
                recv_idle_pct = 17;
            end else if (accepted_count == (2 * total_items) / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------

    function automatic bit field_differs(input string name, input logic [27:0] exp_val,
                                         input logic [27:0] got_val);
        if (got_val === exp_val) return 1'b0;
        if (mismatch_total < 20)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name,
                     exp_val, got_val);
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : result_check
        mtep_pkg::out_item_t exp_r;
        mtep_pkg::out_item_t got_r;
        bit        bad;
        if (aresetn && m_valid && m_ready) begin
            got_r = m_data;
            result_count++;
            if (got_r.kind <= mtep_pkg::KIND_ERROR) kind_seen[got_r.kind]++;
            if (got_r.kind == mtep_pkg::KIND_ERROR) error_seen[got_r.error_code]++;
            if (expected_results.size() == 0) begin
                if (mismatch_total < 20)
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, got_r);
                mismatch_total++;
            end else begin
                exp_r = expected_results.pop_front();
                bad = 1'b0;
                bad |= field_differs("kind", 28'(exp_r.kind), 28'(got_r.kind));
                bad |= field_differs("delta_ticks", exp_r.delta_ticks, got_r.delta_ticks);
                bad |= field_differs("event_type", 28'(exp_r.event_type),
                                     28'(got_r.event_type));
                bad |= field_differs("channel_number", 28'(exp_r.channel_number),
                                     28'(got_r.channel_number));
                bad |= field_differs("first_param", 28'(exp_r.first_param),
                                     28'(got_r.first_param));
                bad |= field_differs("second_param", 28'(exp_r.second_param),
                                     28'(got_r.second_param));
                bad |= field_differs("meta_kind", 28'(exp_r.meta_kind), 28'(got_r.meta_kind));
                bad |= field_differs("payload_length", exp_r.payload_length,
                                     got_r.payload_length);
                bad |= field_differs("payload_byte", 28'(exp_r.payload_byte),
                                     28'(got_r.payload_byte));
                bad |= field_differs("event_done", 28'(exp_r.event_done),
                                     28'(got_r.event_done));
                bad |= field_differs("error_code", 28'(exp_r.error_code),
                                     28'(got_r.error_code));
                if (bad) mismatch_total++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build the stimulus, reset, run, drain and report
    // ------------------------------------------------------------------

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        item_taken     = 1'b0;
        hold_next      = 1'b0;
        mid_hold_done  = 1'b0;
        send_idle_pct  = 17;
        recv_idle_pct  = 62;
        accepted_count = 0;
        result_count   = 0;
        mismatch_total = 0;
        chunk_count    = 0;
        kind_seen      = '{default: 0};
        error_seen     = '{default: 0};
        clear_parser_state();

        // Data byte where a status is due, straight after reset.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h40, 1'b0);
        // Note on with the largest one-byte delta, then a running-status event.
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h90, 1'b0);
        queue_byte(8'h3C, 1'b0);
        queue_byte(8'h64, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h3E, 1'b0);
        queue_byte(8'h40, 1'b0);
        // Program change takes a single data byte.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hC5, 1'b0);
        queue_byte(8'h7F, 1'b0);
        // Largest delta, then channel pressure with a top-bit data byte.
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'hDF, 1'b0);
        queue_byte(8'h81, 1'b0);
        // Meta event with one payload byte, then an empty sysex.
        queue_byte(8'h00, 1'b0);
        queue_byte(mtep_pkg::STATUS_META, 1'b0);
        queue_byte(8'h51, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(mtep_pkg::STATUS_ESCAPE, 1'b0);
        queue_byte(8'h00, 1'b0);
        // Delta that runs past the byte limit.
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // Track ends in the middle of a channel event.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h90, 1'b1);

        // Random chunks; hold the sender back for a full drain twice on the way.
        hold_next = 1'b1;
        while (pending_items.size() < 32 + RANDOM_BYTES) begin
            if (!mid_hold_done && pending_items.size() >= 32 + RANDOM_BYTES / 2) begin
                hold_next     = 1'b1;
                mid_hold_done = 1'b1;
            end
            queue_random_chunk();
        end
        total_items = pending_items.size();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every item to be taken and every result to come back.
        while (pending_items.size() != 0) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        // Then keep the clock running to catch any stray extra result.
        repeat (8) @(posedge aclk);

        if (expected_results.size() != 0)
            $display("%0t ns: %0d results never arrived", $time, expected_results.size());

        $display("Covered %0d track bytes in %0d random chunks plus directed cases; %0d results.",
                 accepted_count, chunk_count, result_count);
        $display("Channel %0d, meta header %0d, meta payload %0d, sysex %0d, errors %0d/%0d/%0d.",
                 kind_seen[mtep_pkg::KIND_CHANNEL], kind_seen[mtep_pkg::KIND_META_HEADER],
                 kind_seen[mtep_pkg::KIND_META_PAYLOAD], kind_seen[mtep_pkg::KIND_SYSEX_HEADER],
                 error_seen[mtep_pkg::ERR_NO_RUNNING], error_seen[mtep_pkg::ERR_OVERLONG],
                 error_seen[mtep_pkg::ERR_TRUNCATED]);
        if (mismatch_total == 0 && expected_results.size() == 0) begin
            $display("** midi_track_event_parser_top: PASSED **");
        end else begin
            $display("** midi_track_event_parser_top: FAILED **");
        end
        $finish;
    end

    // Give up well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("%0t ns: run timed out", $time);
        $display("** midi_track_event_parser_top: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mtep_pkg.sv
sv/midi_track_event_parser_top.sv
sim/tb_top.sv
